FILE: src/ntriples_byte_tokenizer_macros.svh
// Assertion macros shared by the tokenizer modules.
`ifndef NTRIPLES_BYTE_TOKENIZER_MACROS_SVH
`define NTRIPLES_BYTE_TOKENIZER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define NTB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define NTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ntb_pkg.sv
// Types, byte codes and helpers shared by the N-Triples tokenizer modules.
package ntb_pkg;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_US    = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [1:0] ROLE_SUBJ = 2'd0;
    localparam logic [1:0] ROLE_PRED = 2'd1;
    localparam logic [1:0] ROLE_OBJ  = 2'd2;

    localparam logic [1:0] KIND_ABSENT = 2'd0;
    localparam logic [1:0] KIND_IRI    = 2'd1;
    localparam logic [1:0] KIND_LIT    = 2'd2;
    localparam logic [1:0] KIND_BLANK  = 2'd3;

    // Content starts after the opening delimiter, or after "_:" for a blank label.
    localparam logic [1:0] DELIM_SKIP = 2'd1;
    localparam logic [1:0] BLANK_SKIP = 2'd2;

    // Number of result groups buffered between classifier and serializer.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_doc;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]  term_role;
        logic [1:0]  term_kind;
        logic [15:0] term_start;
        logic [15:0] term_length;
        logic        triple_done;
    } term_item_t;

    // All results of one byte: a run of roles from first_role to last_role.
    // Only the first role can carry a real term; the rest are absent.
    typedef struct packed {
        logic [1:0]  first_role;
        logic [1:0]  last_role;
        logic [1:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } term_grp_t;

    function automatic term_grp_t make_grp(input logic [1:0] first_role,
                                           input logic [1:0] last_role,
                                           input logic [1:0] kind,
                                           input logic [15:0] start,
                                           input logic [15:0] length);
        term_grp_t g;
        g.first_role = first_role;
        g.last_role  = last_role;
        g.kind       = kind;
        g.start      = start;
        g.length     = length;
        return g;
    endfunction

endpackage

FILE: src/ntb_front.sv
// Byte classifier: tracks the triple phase and offsets, emits at most one result group per byte.
module ntb_front
    import ntb_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  byte_item_t item,
    output logic       grp_push,
    output term_grp_t  grp
);

    typedef enum logic [3:0] {
        PH_SUBJ_WAIT,
        PH_SUBJ_IRI,
        PH_PRED_WAIT,
        PH_PRED_IRI,
        PH_OBJ_WAIT,
        PH_OBJ_IRI,
        PH_OBJ_LIT,
        PH_OBJ_BPREFIX,
        PH_OBJ_BLANK,
        PH_AFTER_OBJ
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [OFFSET_BITS-1:0] ostart_reg, ostart_next;
    logic [OFFSET_BITS-1:0] olen_reg, olen_next;
    logic                   emit;
    term_grp_t              grp_c;
    logic [OFFSET_BITS-1:0] start_skip1, start_skip2, olen_inc;
    logic [15:0]            cur_start, cur_len;
    logic [7:0]             c;

    function automatic logic [OFFSET_BITS-1:0] sat_add(input logic [OFFSET_BITS-1:0] a,
                                                       input logic [1:0] b);
        logic [OFFSET_BITS:0] s;
        s = {1'b0, a} + {{(OFFSET_BITS-1){1'b0}}, b};
        return s[OFFSET_BITS] ? '1 : s[OFFSET_BITS-1:0];
    endfunction

    assign c           = item.data_byte;
    assign start_skip1 = sat_add(off_reg, DELIM_SKIP);
    assign start_skip2 = sat_add(off_reg, BLANK_SKIP);
    assign olen_inc    = sat_add(olen_reg, 2'd1);
    assign cur_start   = 16'(ostart_reg);
    assign cur_len     = 16'(olen_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        off_next    = sat_add(off_reg, 2'd1);
        ostart_next = ostart_reg;
        olen_next   = olen_reg;
        emit        = 1'b0;
        grp_c       = make_grp(ROLE_SUBJ, ROLE_SUBJ, KIND_ABSENT, 16'd0, 16'd0);

        if (item.end_of_doc)
        begin
            emit = 1'b1;
            unique case (phase_reg)
                PH_SUBJ_IRI:
                    grp_c = make_grp(ROLE_SUBJ, ROLE_OBJ, KIND_IRI, cur_start, cur_len);
                PH_PRED_WAIT:
                    grp_c = make_grp(ROLE_PRED, ROLE_OBJ, KIND_ABSENT, 16'd0, 16'd0);
                PH_PRED_IRI:
                    grp_c = make_grp(ROLE_PRED, ROLE_OBJ, KIND_IRI, cur_start, cur_len);
                PH_OBJ_WAIT:
                    grp_c = make_grp(ROLE_OBJ, ROLE_OBJ, KIND_ABSENT, 16'd0, 16'd0);
                PH_OBJ_IRI:
                    grp_c = make_grp(ROLE_OBJ, ROLE_OBJ, KIND_IRI, cur_start, cur_len);
                PH_OBJ_LIT:
                    grp_c = make_grp(ROLE_OBJ, ROLE_OBJ, KIND_LIT, cur_start, cur_len);
                PH_OBJ_BPREFIX:
                    grp_c = make_grp(ROLE_OBJ, ROLE_OBJ, KIND_BLANK, cur_start, 16'd0);
                PH_OBJ_BLANK:
                    grp_c = make_grp(ROLE_OBJ, ROLE_OBJ, KIND_BLANK, cur_start, cur_len);
                default:
                    emit = 1'b0;
            endcase
            phase_next  = PH_SUBJ_WAIT;
            off_next    = '0;
            ostart_next = '0;
            olen_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SUBJ_WAIT, PH_AFTER_OBJ:
                begin
                    unique case (c) inside
                        CH_LT:
                        begin
                            phase_next  = PH_SUBJ_IRI;
                            ostart_next = start_skip1;
                            olen_next   = '0;
                        end
                        CH_QUOTE:
                        begin
                            emit        = 1'b1;
                            grp_c       = make_grp(ROLE_SUBJ, ROLE_PRED, KIND_ABSENT,
                                                   16'd0, 16'd0);
                            phase_next  = PH_OBJ_LIT;
                            ostart_next = start_skip1;
                            olen_next   = '0;
                        end
                        CH_US:
                        begin
                            emit        = 1'b1;
                            grp_c       = make_grp(ROLE_SUBJ, ROLE_PRED, KIND_ABSENT,
                                                   16'd0, 16'd0);
                            phase_next  = PH_OBJ_BPREFIX;
                            ostart_next = start_skip2;
                            olen_next   = '0;
                        end
                        CH_DOT:
                        begin
                            // A lone dot at triple start is a triple of absent terms;
                            // after an object it just ends the triple.
                            emit       = (phase_reg == PH_SUBJ_WAIT);
                            grp_c      = make_grp(ROLE_SUBJ, ROLE_OBJ, KIND_ABSENT,
                                                  16'd0, 16'd0);
                            phase_next = PH_SUBJ_WAIT;
                        end
                        CH_SP, CH_TAB, CH_LF, CH_CR:
                            phase_next = phase_reg;
                        default:
                            phase_next = PH_SUBJ_WAIT;
                    endcase
                end
                PH_PRED_WAIT, PH_OBJ_WAIT:
                begin
                    unique case (c) inside
                        CH_SP, CH_TAB, CH_LF, CH_CR:
                            phase_next = phase_reg;
                        CH_LT:
                        begin
                            phase_next  = (phase_reg == PH_PRED_WAIT) ? PH_PRED_IRI
                                                                      : PH_OBJ_IRI;
                            ostart_next = start_skip1;
                            olen_next   = '0;
                        end
                        CH_QUOTE:
                        begin
                            emit        = (phase_reg == PH_PRED_WAIT);
                            grp_c       = make_grp(ROLE_PRED, ROLE_PRED, KIND_ABSENT,
                                                   16'd0, 16'd0);
                            phase_next  = PH_OBJ_LIT;
                            ostart_next = start_skip1;
                            olen_next   = '0;
                        end
                        CH_US:
                        begin
                            emit        = (phase_reg == PH_PRED_WAIT);
                            grp_c       = make_grp(ROLE_PRED, ROLE_PRED, KIND_ABSENT,
                                                   16'd0, 16'd0);
                            phase_next  = PH_OBJ_BPREFIX;
                            ostart_next = start_skip2;
                            olen_next   = '0;
                        end
                        default:
                        begin
                            // The remaining terms are absent and the triple ends.
                            emit       = 1'b1;
                            grp_c      = make_grp((phase_reg == PH_PRED_WAIT) ? ROLE_PRED
                                                                              : ROLE_OBJ,
                                                  ROLE_OBJ, KIND_ABSENT, 16'd0, 16'd0);
                            phase_next = PH_SUBJ_WAIT;
                        end
                    endcase
                end
                PH_SUBJ_IRI, PH_PRED_IRI, PH_OBJ_IRI:
                begin
                    if (c == CH_GT)
                    begin
                        emit = 1'b1;
                        if (phase_reg == PH_SUBJ_IRI)
                        begin
                            grp_c      = make_grp(ROLE_SUBJ, ROLE_SUBJ, KIND_IRI,
                                                  cur_start, cur_len);
                            phase_next = PH_PRED_WAIT;
                        end
                        else if (phase_reg == PH_PRED_IRI)
                        begin
                            grp_c      = make_grp(ROLE_PRED, ROLE_PRED, KIND_IRI,
                                                  cur_start, cur_len);
                            phase_next = PH_OBJ_WAIT;
                        end
                        else
                        begin
                            grp_c      = make_grp(ROLE_OBJ, ROLE_OBJ, KIND_IRI,
                                                  cur_start, cur_len);
                            phase_next = PH_AFTER_OBJ;
                        end
                    end
                    else
                    begin
                        olen_next = olen_inc;
                    end
                end
                PH_OBJ_LIT:
                begin
                    if (c == CH_QUOTE)
                    begin
                        emit       = 1'b1;
                        grp_c      = make_grp(ROLE_OBJ, ROLE_OBJ, KIND_LIT, cur_start, cur_len);
                        phase_next = PH_AFTER_OBJ;
                    end
                    else
                    begin
                        olen_next = olen_inc;
                    end
                end
                PH_OBJ_BPREFIX:
                    phase_next = PH_OBJ_BLANK;
                PH_OBJ_BLANK:
                begin
                    unique case (c) inside
                        CH_SP, CH_TAB, CH_LF, CH_CR:
                        begin
                            emit       = 1'b1;
                            grp_c      = make_grp(ROLE_OBJ, ROLE_OBJ, KIND_BLANK,
                                                  cur_start, cur_len);
                            phase_next = PH_AFTER_OBJ;
                        end
                        CH_DOT:
                        begin
                            emit       = 1'b1;
                            grp_c      = make_grp(ROLE_OBJ, ROLE_OBJ, KIND_BLANK,
                                                  cur_start, cur_len);
                            phase_next = PH_SUBJ_WAIT;
                        end
                        default:
                            olen_next = olen_inc;
                    endcase
                end
                default:
                    phase_next = PH_SUBJ_WAIT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SUBJ_WAIT;
            off_reg    <= '0;
            ostart_reg <= '0;
            olen_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            ostart_reg <= ostart_next;
            olen_reg   <= olen_next;
        end
    end

    assign grp_push = accept && emit;
    assign grp      = grp_c;

endmodule

FILE: src/ntb_queue.sv
// Small register queue of result groups between classifier and serializer.
`include "ntriples_byte_tokenizer_macros.svh"

module ntb_queue
    import ntb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  term_grp_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output term_grp_t rd_data,
    output logic      nonempty
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    term_grp_t             entries [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  do_wr, do_rd;

    assign full     = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && nonempty;
    assign rd_data  = entries[rd_ptr_reg];

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : PTR_BITS'(p + 1'b1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= CNT_BITS'(count_reg + 1'b1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= CNT_BITS'(count_reg - 1'b1);
            end
        end
    end

    `NTB_ASSERT(a_count_bound, count_reg <= CNT_BITS'(QUEUE_DEPTH), "queue count overflow")
    `NTB_ASSERT_NEXT(a_write_counts, do_wr && !do_rd, count_reg == CNT_BITS'($past(count_reg) + 1'b1), "write not counted")

endmodule

FILE: src/ntb_back.sv
// Serializer: expands each result group into one term transaction per cycle, stalling while an unpopped one waits.
`include "ntriples_byte_tokenizer_macros.svh"

module ntb_back
    import ntb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       grp_valid,
    input  term_grp_t  grp,
    output logic       grp_pop,
    output logic       empty,
    input  logic       pop,
    output term_item_t term
);

    logic       in_grp_reg, in_grp_next;
    logic [1:0] role_reg, role_next;
    logic       out_valid_reg, out_valid_next;
    term_item_t out_reg, out_next;
    logic       load;
    logic [1:0] cur_role;
    logic       is_first, is_last;

    assign load     = grp_valid && (!out_valid_reg || pop);
    assign cur_role = in_grp_reg ? role_reg : grp.first_role;
    assign is_first = (cur_role == grp.first_role);
    assign is_last  = (cur_role == grp.last_role);

    always_comb
    begin
        in_grp_next    = in_grp_reg;
        role_next      = role_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        grp_pop        = 1'b0;
        if (load)
        begin
            out_valid_next       = 1'b1;
            out_next.term_role   = cur_role;
            out_next.term_kind   = is_first ? grp.kind : KIND_ABSENT;
            out_next.term_start  = is_first ? grp.start : 16'd0;
            out_next.term_length = is_first ? grp.length : 16'd0;
            out_next.triple_done = (cur_role == ROLE_OBJ);
            if (is_last)
            begin
                grp_pop     = 1'b1;
                in_grp_next = 1'b0;
            end
            else
            begin
                in_grp_next = 1'b1;
                role_next   = 2'(cur_role + 1'b1);
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_grp_reg    <= 1'b0;
            role_reg      <= ROLE_SUBJ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_grp_reg    <= in_grp_next;
            role_reg      <= role_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty = !out_valid_reg;
    assign term  = out_reg;

    `NTB_ASSERT(a_done_on_object, !out_valid_reg || (out_reg.triple_done == (out_reg.term_role == ROLE_OBJ)), "triple_done does not match role")
    `NTB_ASSERT_NEXT(a_pop_emits_last, grp_pop, out_valid_reg && out_reg.term_role == $past(grp.last_role), "group retired before its last role")

endmodule

FILE: src/ntriples_byte_tokenizer.sv
// A byte's group is written into the group queue at the edge that accepts the byte; the
// serializer loads its first term from the queue head into the output register for popping.
// One byte per cycle is taken while the queue has room; each closed term is one transaction.
// A four-entry group queue absorbs bursts, so full rises only when results back up.
// Reset (rst_n low, asynchronous) returns to the start of a triple at offset zero,
// empties the queue and drops any term transaction waiting on the result side.
module ntriples_byte_tokenizer
    import ntb_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  byte_item_t item,
    output logic       empty,
    input  logic       pop,
    output term_item_t term
);

    // A byte is taken whenever the group queue has room, even if it closes
    // no term, so the classifier never waits on the serializer directly.
    logic      accept;
    logic      grp_push;
    term_grp_t grp_in;
    logic      q_full;
    logic      q_nonempty;
    term_grp_t q_head;
    logic      q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Front: one step of the triple grammar per byte. Every term that a byte
    // closes, real or absent, is packed into a single group of roles.
    ntb_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .grp_push (grp_push),
        .grp      (grp_in)
    );

    // The queue decouples a multi-term byte from the bytes that follow it.
    ntb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (grp_push),
        .wr_data  (grp_in),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_data  (q_head),
        .nonempty (q_nonempty)
    );

    // Back: walks each group role by role into the output register, which reloads
    // in the same cycle that its current transaction is popped if a group is waiting.
    ntb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (q_nonempty),
        .grp       (q_head),
        .grp_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .term      (term)
    );

endmodule
